[hw/rtl/bsseq_pkg.sv]
// shared types, tone tables and constants for the buzzer sound effect sequencer
package bsseq_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_PLAY = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    localparam int NUM_EFFECTS = 8;
    localparam int MAX_TONES   = 5;

    localparam logic [3:0]  LAST_EFFECT_ID = 4'd8;
    localparam logic [2:0]  LAST_STEP      = 3'd4;
    localparam logic [8:0]  ELAPSED_MAX    = 9'd511;
    localparam logic [6:0]  VOLUME_RESET   = 7'd80;
    localparam logic [6:0]  VOLUME_MAX     = 7'd100;
    localparam logic [15:0] PERIOD_RESET   = 16'd999;
    localparam logic [15:0] COMPARE_RESET  = 16'd500;

    // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 2**20
    localparam logic [19:0] DIV100_MUL   = 20'd671089;
    localparam int          DIV100_SHIFT = 26;

    // timer reload values, 1000000 / freq - 1; zero marks a silent tone
    localparam logic [11:0] TONE_PERIOD [NUM_EFFECTS][MAX_TONES] = '{
        '{12'd1911, 12'd1516, 12'd1274, 12'd954,  12'd757 },
        '{12'd954,  12'd1274, 12'd1516, 12'd1911, 12'd0   },
        '{12'd1249, 12'd0,    12'd1665, 12'd0,    12'd0   },
        '{12'd1665, 12'd0,    12'd1249, 12'd0,    12'd0   },
        '{12'd1249, 12'd0,    12'd0,    12'd0,    12'd0   },
        '{12'd1665, 12'd0,    12'd0,    12'd0,    12'd0   },
        '{12'd3332, 12'd0,    12'd3332, 12'd0,    12'd3332},
        '{12'd999,  12'd0,    12'd999,  12'd0,    12'd0   }
    };

    localparam logic [8:0] TONE_MS [NUM_EFFECTS][MAX_TONES] = '{
        '{9'd300, 9'd300, 9'd100, 9'd100, 9'd100},
        '{9'd100, 9'd100, 9'd100, 9'd150, 9'd0  },
        '{9'd50,  9'd20,  9'd50,  9'd0,   9'd0  },
        '{9'd50,  9'd20,  9'd50,  9'd0,   9'd0  },
        '{9'd30,  9'd0,   9'd0,   9'd0,   9'd0  },
        '{9'd20,  9'd0,   9'd0,   9'd0,   9'd0  },
        '{9'd80,  9'd50,  9'd80,  9'd50,  9'd80 },
        '{9'd50,  9'd50,  9'd50,  9'd0,   9'd0  }
    };

    localparam logic [2:0] TONE_COUNT [NUM_EFFECTS] = '{
        3'd5, 3'd4, 3'd3, 3'd3, 3'd1, 3'd1, 3'd5, 3'd3
    };

    // steps past the end of the list read as silent
    function automatic logic [11:0] tone_period(input logic [2:0] eff, input logic [2:0] idx);
        logic [11:0] p;
        p = 12'd0;
        if (idx <= LAST_STEP) begin
            p = TONE_PERIOD[eff][idx];
        end
        return p;
    endfunction

    function automatic logic [8:0] tone_ms(input logic [2:0] eff, input logic [2:0] idx);
        logic [8:0] d;
        d = 9'd0;
        if (idx <= LAST_STEP) begin
            d = TONE_MS[eff][idx];
        end
        return d;
    endfunction

endpackage

[hw/rtl/buzzer_sound_effect_sequencer.sv]
// buzzer sound effect sequencer: tone tables, playback state and pwm settings
//
// One command per s_ transfer: tick (one millisecond), play an effect, or stop.
// Every accepted command yields exactly one m_ transfer that shows the pwm
// settings and playback status after that command.
// s_tdata: [1:0] cmd, [5:2] sound_id, upper bits zero.
// m_tdata: [0] output_enable, [16:1] period_count, [32:17] compare_count,
//          [33] busy_res, [37:34] active_sound, upper bits zero.
// cfg_wr_en / cfg_wr_data write volume_percent; values above 100 are stored as 100.
// The new volume applies from the next tone on, not to an effect's first tone.
// m_tvalid rises in the cycle after the s_ transfer, and one command is
// taken every cycle while m_ is not stalled: the state update is a single
// registered pass, and the volume product for the coming tone is held in a
// register so that the divide by 100 on a tone change is one constant multiply.
// Reset clears playback, loads period 999, compare 500, volume 80, and drops
// m_tvalid. While m_tvalid is high and m_tready low, s_tready is low and the
// result is held.
module buzzer_sound_effect_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] cmd, [5:2] sound_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] output_enable, [16:1] period_count,
                                   // [32:17] compare_count, [33] busy_res,
                                   // [37:34] active_sound
);

    logic [6:0]  volume_reg,  volume_next;
    logic        playing_reg, playing_next;
    logic [3:0]  effect_reg,  effect_next;
    logic [2:0]  step_reg,    step_next;
    logic [8:0]  elapsed_reg, elapsed_next;
    logic [15:0] period_reg,  period_next;
    logic [15:0] compare_reg, compare_next;
    logic        enable_reg,  enable_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [18:0] scaled_prod_reg, scaled_prod_next;

    logic        accept;
    logic [1:0]  cmd;
    logic [3:0]  sound_id;
    logic [3:0]  eff_full;
    logic [2:0]  eff;
    logic [2:0]  step_clamp;
    logic [2:0]  step_after;
    logic [8:0]  elapsed_inc;
    logic        advance;
    logic [11:0] after_period;
    logic [6:0]  vol_clamp;
    logic [6:0]  vol_src;
    logic [38:0] quot_prod;
    logic [15:0] scaled_compare;
    logic [3:0]  id_full;
    logic [11:0] first_period;

    assign cmd      = s_tdata[1:0];
    assign sound_id = s_tdata[5:2];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign eff_full    = effect_reg - 4'd1;
    assign eff         = eff_full[2:0];
    assign step_clamp  = (step_reg > bsseq_pkg::LAST_STEP) ? bsseq_pkg::LAST_STEP : step_reg;
    assign step_after  = step_clamp + 3'd1;
    assign elapsed_inc = (elapsed_reg < bsseq_pkg::ELAPSED_MAX) ? elapsed_reg + 9'd1
                                                                  : elapsed_reg;
    assign advance     = elapsed_inc >= bsseq_pkg::tone_ms(eff, step_clamp);
    assign after_period = bsseq_pkg::tone_period(eff, step_after);

    // volume product for the tone that follows, bypassing a write in the same cycle
    assign vol_clamp        = (cfg_wr_data > bsseq_pkg::VOLUME_MAX) ? bsseq_pkg::VOLUME_MAX
                                                                     : cfg_wr_data;
    assign vol_src          = cfg_wr_en ? vol_clamp : volume_reg;
    assign scaled_prod_next = 19'(after_period) * 19'(vol_src);
    assign volume_next      = cfg_wr_en ? vol_clamp : volume_reg;

    assign quot_prod      = 39'(scaled_prod_reg) * 39'(bsseq_pkg::DIV100_MUL);
    assign scaled_compare = 16'(quot_prod[38:bsseq_pkg::DIV100_SHIFT]);

    assign id_full      = sound_id - 4'd1;
    assign first_period = bsseq_pkg::tone_period(id_full[2:0], 3'd0);

    always_comb begin
        playing_next  = playing_reg;
        effect_next   = effect_reg;
        step_next     = step_reg;
        elapsed_next  = elapsed_reg;
        period_next   = period_reg;
        compare_next  = compare_reg;
        enable_next   = enable_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (accept) begin
            m_tvalid_next = 1'b1;
            case (cmd)
                bsseq_pkg::CMD_TICK: begin
                    if (playing_reg && (effect_reg inside {[4'd1:bsseq_pkg::LAST_EFFECT_ID]})) begin
                        elapsed_next = elapsed_inc;
                        if (advance) begin
                            if (step_after >= bsseq_pkg::TONE_COUNT[eff]) begin
                                enable_next  = 1'b0;
                                compare_next = 16'd0;
                                playing_next = 1'b0;
                                effect_next  = 4'd0;
                                step_next    = 3'd0;
                                elapsed_next = 9'd0;
                            end else begin
                                step_next    = step_after;
                                elapsed_next = 9'd0;
                                if (after_period == 12'd0) begin
                                    enable_next  = 1'b0;
                                    compare_next = 16'd0;
                                end else begin
                                    period_next  = 16'(after_period);
                                    compare_next = scaled_compare;
                                    enable_next  = 1'b1;
                                end
                            end
                        end
                    end else if (playing_reg) begin
                        enable_next  = 1'b0;
                        compare_next = 16'd0;
                        playing_next = 1'b0;
                        effect_next  = 4'd0;
                        step_next    = 3'd0;
                        elapsed_next = 9'd0;
                    end
                end
                bsseq_pkg::CMD_PLAY: begin
                    if (sound_id <= bsseq_pkg::LAST_EFFECT_ID) begin
                        enable_next  = 1'b0;
                        compare_next = 16'd0;
                        playing_next = 1'b0;
                        effect_next  = 4'd0;
                        step_next    = 3'd0;
                        elapsed_next = 9'd0;
                        if (sound_id != 4'd0) begin
                            playing_next = 1'b1;
                            effect_next  = sound_id;
                            if (first_period != 12'd0) begin
                                period_next  = 16'(first_period);
                                compare_next = 16'(first_period[11:1]);
                                enable_next  = 1'b1;
                            end
                        end
                    end
                end
                bsseq_pkg::CMD_STOP: begin
                    enable_next  = 1'b0;
                    compare_next = 16'd0;
                    playing_next = 1'b0;
                    effect_next  = 4'd0;
                    step_next    = 3'd0;
                    elapsed_next = 9'd0;
                end
                default: begin
                    // unused command code, state unchanged
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg   <= bsseq_pkg::VOLUME_RESET;
            playing_reg  <= 1'b0;
            effect_reg   <= 4'd0;
            step_reg     <= 3'd0;
            elapsed_reg  <= 9'd0;
            period_reg   <= bsseq_pkg::PERIOD_RESET;
            compare_reg  <= bsseq_pkg::COMPARE_RESET;
            enable_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            volume_reg   <= volume_next;
            playing_reg  <= playing_next;
            effect_reg   <= effect_next;
            step_reg     <= step_next;
            elapsed_reg  <= elapsed_next;
            period_reg   <= period_next;
            compare_reg  <= compare_next;
            enable_reg   <= enable_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scaled_prod_reg <= scaled_prod_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, effect_reg, playing_reg, compare_reg, period_reg, enable_reg};

    ap_busy_has_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> (effect_reg != 4'd0 && effect_reg <= bsseq_pkg::LAST_EFFECT_ID))
        else $error("busy without a valid effect id");

    ap_idle_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        !playing_reg |-> (effect_reg == 4'd0 && step_reg == 3'd0 && elapsed_reg == 9'd0))
        else $error("idle with leftover playback state");

    ap_enable_needs_play: assert property (@(posedge aclk) disable iff (!aresetn)
        enable_reg |-> (playing_reg && compare_reg <= period_reg))
        else $error("output enabled while idle or duty above period");

    ap_volume_range: assert property (@(posedge aclk) disable iff (!aresetn)
        volume_reg <= bsseq_pkg::VOLUME_MAX)
        else $error("volume above 100");

    ap_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
